[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; pulled in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active low).
`define TPP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TPP_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/tpp_pkg.sv]
// Shared widths, register indexes and types for the timer prescaler/period block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tpp_pkg;

  // Field widths
  localparam int unsigned CLK_W  = 32;
  localparam int unsigned FREQ_W = 32;
  localparam int unsigned LIM_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  // (limit + 1) * frequency needs one bit more than the limit
  localparam int unsigned PROD_W = LIM_W + 1 + FREQ_W;

  localparam int unsigned TPP_TIMER_WIDTH_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LIMIT    = 2'd2;

  // Reset values
  localparam logic [CLK_W-1:0] CLOCK_RATE_RST = 32'd84000000;
  localparam logic [LIM_W-1:0] PRE_LIMIT_RST  = 16'hFFFF;
  localparam logic [LIM_W-1:0] PER_LIMIT_RST  = 16'hFFFF;

  // Divider result back to the sequencer
  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

[design/tpp_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all three quotients.
// Depends on tpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpp_div import tpp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [CLK_W-1:0]  num,
  input  wire logic [PROD_W-1:0] den,
  output div_res_t               res
);

  localparam int unsigned CNT_W = $clog2(CLK_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CLK_W-1:0]  rem_r, rem_nxt;
  logic [CLK_W-1:0]  quo_r, quo_nxt;
  logic [PROD_W-1:0] den_r, den_nxt;

  logic [CLK_W:0]    rem_sh;
  logic [PROD_W-1:0] rem_ext;
  logic [PROD_W-1:0] diff;
  logic              ge;

  // One restoring step: shift in next numerator bit, subtract if it fits
  assign rem_sh  = {rem_r, quo_r[CLK_W-1]};
  assign rem_ext = PROD_W'(rem_sh);
  assign ge      = (rem_ext >= den_r);
  assign diff    = rem_ext - den_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CLK_W-1:0] : rem_sh[CLK_W-1:0];
      quo_nxt = {quo_r[CLK_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CLK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

`default_nettype wire

[design/timer_prescaler_period_calc.sv]
// Top level: config registers, sequencer, shared multiplier and result register.
// Depends on tpp_pkg and tpp_div.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | in_wanted_frequency
//  out     | out | out_valid / out_ready | out_valid_res, out_prescaler_value,
//          |     |                       | out_period_value
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A zero frequency goes from the idle state straight to the finishing state and
// on into the result register. Otherwise two or three quotients run in turn
// through the shared 32-step divider, the third only when the period must be
// pinned to its limit. in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; the next transaction is
// taken while it waits. Config writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none

module timer_prescaler_period_calc import tpp_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = TPP_TIMER_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FREQ_W-1:0]    in_wanted_frequency,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_valid_res,
  output logic [LIM_W-1:0]          out_prescaler_value,
  output logic [LIM_W-1:0]          out_period_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  // Limits saturate to the timer's counter width
  localparam int unsigned SAT_BITS = (TIMER_WIDTH < LIM_W) ? TIMER_WIDTH : LIM_W;
  localparam logic [LIM_W-1:0] LIM_TOP = LIM_W'((64'd1 << SAT_BITS) - 64'd1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_W1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_W2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_W3   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;

  logic [CLK_W-1:0]  clock_rate_r;
  logic [LIM_W-1:0]  pre_limit_r;
  logic [LIM_W-1:0]  per_limit_r;

  logic [3:0]        state_r, state_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic              vres_r, vres_nxt;
  logic [LIM_W-1:0]  pre_r, pre_nxt;
  logic [LIM_W-1:0]  per_r, per_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_vres_r, out_vres_nxt;
  logic [LIM_W-1:0]  out_pre_r, out_pre_nxt;
  logic [LIM_W-1:0]  out_per_r, out_per_nxt;

  logic [LIM_W-1:0]  pre_lim;
  logic [LIM_W-1:0]  per_lim;
  logic [LIM_W:0]    mul_a;
  logic [PROD_W-1:0] product;
  logic              div_start;
  div_res_t          div_res;
  logic [CLK_W-1:0]  quo_m1;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= CLOCK_RATE_RST;
      pre_limit_r  <= PRE_LIMIT_RST;
      per_limit_r  <= PER_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CLOCK_RATE:      clock_rate_r <= cfg_data[CLK_W-1:0];
        CFG_PRESCALER_LIMIT: pre_limit_r  <= cfg_data[LIM_W-1:0];
        CFG_PERIOD_LIMIT:    per_limit_r  <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign pre_lim = (pre_limit_r > LIM_TOP) ? LIM_TOP : pre_limit_r;
  assign per_lim = (per_limit_r > LIM_TOP) ? LIM_TOP : per_limit_r;

  // Shared multiplier; the divider registers the product as its divisor
  assign product = PROD_W'(mul_a) * PROD_W'(freq_r);
  assign quo_m1  = div_res.quo - 1'b1;

  tpp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (clock_rate_r),
    .den   (product),
    .res   (div_res)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    freq_nxt      = freq_r;
    vres_nxt      = vres_r;
    pre_nxt       = pre_r;
    per_nxt       = per_r;
    mul_a         = '0;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_vres_nxt  = out_vres_r;
    out_pre_nxt   = out_pre_r;
    out_per_nxt   = out_per_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          freq_nxt = in_wanted_frequency;
          if (in_wanted_frequency == '0) begin
            vres_nxt  = 1'b0;
            pre_nxt   = '0;
            per_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            vres_nxt  = 1'b1;
            state_nxt = S_M1;
          end
        end
      end
      // first guess: clk / ((per_lim + 1) * freq), capped
      S_M1: begin
        mul_a     = {1'b0, per_lim} + 1'b1;
        div_start = 1'b1;
        state_nxt = S_W1;
      end
      S_W1: begin
        if (div_res.done) begin
          pre_nxt   = (div_res.quo > CLK_W'(pre_lim)) ? pre_lim : div_res.quo[LIM_W-1:0];
          state_nxt = S_M2;
        end
      end
      // period for that prescaler
      S_M2: begin
        mul_a     = {1'b0, pre_r} + 1'b1;
        div_start = 1'b1;
        state_nxt = S_W2;
      end
      S_W2: begin
        if (div_res.done) begin
          if (div_res.quo > CLK_W'(per_lim)) begin
            per_nxt   = per_lim;
            state_nxt = S_M3;
          end else begin
            per_nxt   = div_res.quo[LIM_W-1:0];
            state_nxt = S_FIN;
          end
        end
      end
      // period pinned: prescaler = clk / (per_lim * freq) - 1, wraps then clamps
      S_M3: begin
        mul_a     = {1'b0, per_lim};
        div_start = 1'b1;
        state_nxt = S_W3;
      end
      S_W3: begin
        if (div_res.done) begin
          pre_nxt   = (quo_m1 > CLK_W'(pre_lim)) ? pre_lim : quo_m1[LIM_W-1:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_vres_nxt  = vres_r;
          out_pre_nxt   = pre_r;
          out_per_nxt   = per_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    freq_r     <= freq_nxt;
    vres_r     <= vres_nxt;
    pre_r      <= pre_nxt;
    per_r      <= per_nxt;
    out_vres_r <= out_vres_nxt;
    out_pre_r  <= out_pre_nxt;
    out_per_r  <= out_per_nxt;
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_valid_res       = out_vres_r;
  assign out_prescaler_value = out_pre_r;
  assign out_period_value    = out_per_r;

endmodule

`default_nettype wire

[design/tpp_checker.sv]
// Port-level checks for timer_prescaler_period_calc, attached by bind.
// Depends on tpp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tpp_checker import tpp_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_valid_res,
  input wire logic [LIM_W-1:0]     out_prescaler_value,
  input wire logic [LIM_W-1:0]     out_period_value
);

  // stalled result holds
  `TPP_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_prescaler_value) && $stable(out_period_value) && $stable(out_valid_res), "result changed while stalled")
  // one transaction at a time: busy right after an accept
  `TPP_ASSERT_RST(a_busy_after_in, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while busy")
  // a zero-frequency result carries zero fields
  `TPP_ASSERT_RST(a_invalid_zero, clk, rst_n, out_valid && !out_valid_res |-> out_prescaler_value == '0 && out_period_value == '0, "invalid result with nonzero fields")
  // no result straight out of reset
  `TPP_ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind timer_prescaler_period_calc tpp_checker u_tpp_checker (.*);

`default_nettype wire

[tb/sv/timer_prescaler_period_calc_test.sv]
// Self-checking testbench for timer_prescaler_period_calc: random-gap driver and
// monitor around a local prescaler/period predictor, with phased config writes.
// Depends on tpp_pkg and the timer_prescaler_period_calc RTL.
`timescale 1ns / 1ps

module timer_prescaler_period_calc_test;
  import tpp_pkg::*;

  localparam int unsigned TIMER_W = TPP_TIMER_WIDTH_DEF;
  localparam logic [63:0] SAT_TOP = (64'd1 << TIMER_W) - 64'd1;
  // Index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int HOLD_CYCLES = 800;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic             valid_res;
    logic [LIM_W-1:0] prescaler;
    logic [LIM_W-1:0] period;
  } timer_setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FREQ_W-1:0]    in_wanted_frequency = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_valid_res;
  logic [LIM_W-1:0]     out_prescaler_value;
  logic [LIM_W-1:0]     out_period_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Shadow copy of the config registers
  logic [CLK_W-1:0] clock_rate_q = CLOCK_RATE_RST;
  logic [LIM_W-1:0] pre_limit_q  = PRE_LIMIT_RST;
  logic [LIM_W-1:0] per_limit_q  = PER_LIMIT_RST;

  logic [FREQ_W-1:0] freq_queue[$];
  timer_setting_t    setting_q[$];
  timer_setting_t    oldest;
  int  mismatches = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  no_gaps = 1'b0;

  timer_prescaler_period_calc #(
    .TIMER_WIDTH(TIMER_W)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_wanted_frequency (in_wanted_frequency),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_valid_res       (out_valid_res),
    .out_prescaler_value (out_prescaler_value),
    .out_period_value    (out_period_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected prescaler and period for one wanted frequency, exact at 64 bits
  function automatic timer_setting_t calc_timer_setting(input logic [FREQ_W-1:0] freq);
    logic [63:0] f, rate, pre_top, per_top, pre, per, den;
    timer_setting_t res;
    f       = 64'(freq);
    rate    = 64'(clock_rate_q);
    pre_top = (64'(pre_limit_q) > SAT_TOP) ? SAT_TOP : 64'(pre_limit_q);
    per_top = (64'(per_limit_q) > SAT_TOP) ? SAT_TOP : 64'(per_limit_q);
    res = '0;
    if (f != 64'd0) begin
      // smallest prescaler that lets the period fit, capped
      pre = rate / ((per_top + 64'd1) * f);
      if (pre > pre_top) pre = pre_top;
      per = rate / ((pre + 64'd1) * f);
      // still too long: pin the period, derive the prescaler from it
      if (per > per_top) begin
        per = per_top;
        den = per * f;
        pre = (den == 64'd0) ? '1 : rate / den;
        pre = pre - 64'd1;  // wraps to all ones on a zero quotient
      end
      if (pre > pre_top) pre = pre_top;
      res.valid_res = 1'b1;
      res.prescaler = pre[LIM_W-1:0];
      res.period    = per[LIM_W-1:0];
    end
    return res;
  endfunction

  // Idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [FREQ_W-1:0] random_frequency();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return $urandom();
      3, 4:    return $urandom_range(1, 1000);
      5:       return $urandom_range(1, 20);
      6:       return (clock_rate_q >> $urandom_range(0, 31)) + $urandom_range(0, 2);
      7:       return '1 - $urandom_range(0, 3);
      default: return $urandom_range(1000, 2000000);
    endcase
  endfunction

  function automatic logic [CLK_W-1:0] random_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3, 4:    return $urandom();
      default: return $urandom_range(1000000, 200000000);
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] random_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'd1;
      2:       return '1;
      3, 4:    return $urandom_range(2, 255);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Shadow registers follow every accepted config transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_q <= CLOCK_RATE_RST;
      pre_limit_q  <= PRE_LIMIT_RST;
      per_limit_q  <= PER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLOCK_RATE:      clock_rate_q <= cfg_data;
        CFG_PRESCALER_LIMIT: pre_limit_q  <= cfg_data[LIM_W-1:0];
        CFG_PERIOD_LIMIT:    per_limit_q  <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Driver: offers queued frequencies, records the expected setting on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid            <= 1'b0;
      in_wanted_frequency <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready)
        setting_q.push_back(calc_timer_setting(in_wanted_frequency));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (freq_queue.size() > 0) begin
          in_valid            <= 1'b1;
          in_wanted_frequency <= freq_queue.pop_front();
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (setting_q.size() == 0) begin
          $display("%0t: unexpected result valid_res=%0b prescaler=%0d period=%0d",
                   $time, out_valid_res, out_prescaler_value, out_period_value);
          mismatches++;
        end else begin
          oldest = setting_q.pop_front();
          if (out_valid_res !== oldest.valid_res) begin
            $display("%0t: valid_res expected %0b actual %0b",
                     $time, oldest.valid_res, out_valid_res);
            mismatches++;
          end
          if (out_prescaler_value !== oldest.prescaler) begin
            $display("%0t: prescaler_value expected %0d actual %0d",
                     $time, oldest.prescaler, out_prescaler_value);
            mismatches++;
          end
          if (out_period_value !== oldest.period) begin
            $display("%0t: period_value expected %0d actual %0d",
                     $time, oldest.period, out_period_value);
            mismatches++;
          end
        end
      end
      // long hold-off so the block backs up into its input
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Limits go out with junk in the upper data bits
  task automatic set_config(input logic [CLK_W-1:0] rate, input logic [LIM_W-1:0] pre_lim,
                            input logic [LIM_W-1:0] per_lim);
    write_reg(CFG_CLOCK_RATE, rate);
    write_reg(CFG_PRESCALER_LIMIT, {16'($urandom()), pre_lim});
    write_reg(CFG_PERIOD_LIMIT, {16'($urandom()), per_lim});
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (freq_queue.size() != 0 || in_valid || setting_q.size() != 0);
  endtask

  initial begin
    int phase;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset config: zero, extremes, boundary around the 16-bit period limit
    freq_queue = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd84000000, 32'd84000001,
                   32'd1281, 32'd1282, 32'hAAAA_AAAA, 32'h5555_5555};
    wait_idle();
    // Huge clock, prescaler limit zero: period gets pinned, prescaler clamped
    set_config('1, '0, '1);
    freq_queue = '{32'd1, 32'd2, 32'd65537, 32'hFFFF_FFFF};
    wait_idle();
    // Zero clock rate
    set_config('0, '1, '1);
    freq_queue = '{32'd1, 32'hFFFF_FFFF, 32'd0};
    wait_idle();
    // Zero period limit: recompute divides by zero
    set_config(32'd84000000, 16'd100, '0);
    freq_queue = '{32'd1, 32'd84000000, 32'hFFFF_FFFF};
    wait_idle();
    // Unit clock and period limit, plus a write to the unmapped index
    set_config(32'd1, '1, 16'd1);
    write_reg(CFG_UNMAPPED, $urandom());
    @(negedge clk);
    freq_queue = '{32'd1, 32'd2, 32'hFFFF_FFFF};

    // Random phases, each with a fresh config
    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      set_config(random_rate(), random_limit(), random_limit());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_UNMAPPED, $urandom());
        @(negedge clk);
      end
      no_gaps = (phase == 5);
      if (phase == 2) hold_req = 1'b1;
      for (n = 0; n < 110; n++) freq_queue.push_back(random_frequency());
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && setting_q.size() == 0)
      $display("timer_prescaler_period_calc verification clean");
    else
      $display("timer_prescaler_period_calc verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("timer_prescaler_period_calc verification failed");
    $finish;
  end

endmodule
